// ===== rtl/key_matrix_event_scanner_assert.svh =====
// Assertion macros used by the key matrix event scanner datapath.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef KEY_MATRIX_EVENT_SCANNER_ASSERT_SVH
`define KEY_MATRIX_EVENT_SCANNER_ASSERT_SVH

// same-cycle implication
`define KMS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kms: implication check failed");

// next-cycle implication
`define KMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kms: next-cycle check failed");

`endif

// ===== rtl/kms_pkg.sv =====
// Package for the key matrix event scanner: constants, scan order, types.
// No dependencies.
`timescale 1ns / 1ps

package kms_pkg;

  localparam int ROWS     = 8;
  localparam int COLS     = 5;
  localparam int MAP_SIZE = 40;
  localparam int POS_W    = 6;
  localparam int ROW_W    = 3;
  localparam int COL_W    = 3;
  localparam int CNT_W    = 20;
  localparam int DEB_W    = 16;
  localparam int IVL_W    = 19;
  localparam int CFG_W    = 1;

  localparam logic [ROW_W-1:0] CAPS_ROW  = 3'd5;
  localparam logic [COL_W-1:0] CAPS_COL  = 3'd4;
  localparam logic [ROW_W-1:0] SYM_ROW   = 3'd7;
  localparam logic [COL_W-1:0] SYM_COL   = 3'd3;
  localparam logic [POS_W-1:0] SHIFT_POS = POS_W'(5 * COLS + 4);
  localparam logic [POS_W-1:0] SYM_POS   = POS_W'(7 * COLS + 3);
  localparam logic [POS_W-1:0] LAST_STEP = POS_W'(MAP_SIZE - 1);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  localparam logic [CFG_W-1:0] CFG_ENABLE   = 1'b0;
  localparam logic [CFG_W-1:0] CFG_DEBOUNCE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic tick;
    logic load;
    logic advance;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_poll;
    logic honored;
    logic cur_emit;
    logic cur_last;
    logic out_free;
  } sts_t;

  // map scan step to matrix position: shift, symbol shift, then the rest in order
  function automatic logic [POS_W-1:0] seq_pos(input logic [POS_W-1:0] step);
    logic [POS_W-1:0] p;
    begin
      p = step - POS_W'(2);
      if (step == POS_W'(0)) begin
        p = SHIFT_POS;
      end else if (step == POS_W'(1)) begin
        p = SYM_POS;
      end else begin
        if (p >= SHIFT_POS) p = p + POS_W'(1);
        if (p >= SYM_POS) p = p + POS_W'(1);
      end
      return p;
    end
  endfunction

  function automatic logic [ROW_W-1:0] pos_row(input logic [POS_W-1:0] p);
    logic [ROW_W-1:0] r;
    begin
      r = '0;
      for (int i = 1; i < ROWS; i++) begin
        if (p >= POS_W'(i * COLS)) r = ROW_W'(i);
      end
      return r;
    end
  endfunction

  function automatic logic [COL_W-1:0] pos_col(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] base;
    begin
      base = POS_W'(pos_row(p)) * POS_W'(COLS);
      return COL_W'(p - base);
    end
  endfunction

endpackage

// ===== rtl/kms_datapath.sv =====
// Datapath of the key matrix event scanner: config, counter, maps, output register.
// Depends on kms_pkg and key_matrix_event_scanner_assert.svh.
`timescale 1ns / 1ps
`include "key_matrix_event_scanner_assert.svh"

module kms_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kms_pkg::cmd_t                   cmd,
  output kms_pkg::sts_t                   sts,
  input  logic                            in_kind,
  input  logic [kms_pkg::MAP_SIZE-1:0]    in_key_down,
  input  logic                            in_menu_active,
  input  logic                            cfg_valid,
  input  logic [kms_pkg::CFG_W-1:0]       cfg_index,
  input  logic [kms_pkg::DEB_W-1:0]       cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [kms_pkg::ROW_W-1:0]       out_row,
  output logic [kms_pkg::COL_W-1:0]       out_column,
  output logic                            out_is_press,
  output logic                            out_last
);

  logic                          enable_r;
  logic [kms_pkg::DEB_W-1:0]     debounce_r;
  logic [kms_pkg::CNT_W-1:0]     since_r, since_nxt;
  logic [kms_pkg::MAP_SIZE-1:0]  pressed_r, pressed_nxt;
  logic [kms_pkg::MAP_SIZE-1:0]  key_r;
  logic [kms_pkg::MAP_SIZE-1:0]  pend_r;
  logic [kms_pkg::POS_W-1:0]     step_r;
  logic                          out_valid_r;
  logic [kms_pkg::ROW_W-1:0]     out_row_r;
  logic [kms_pkg::COL_W-1:0]     out_column_r;
  logic                          out_is_press_r;
  logic                          out_last_r;

  logic [kms_pkg::POS_W-1:0]     pos;
  logic [kms_pkg::MAP_SIZE-1:0]  pos_bit;
  logic [kms_pkg::MAP_SIZE-1:0]  rest;
  logic [kms_pkg::IVL_W-1:0]     interval;
  logic [kms_pkg::MAP_SIZE-1:0]  fixed_mask;
  logic                          cur_press;

  assign pos        = kms_pkg::seq_pos(step_r);
  assign pos_bit    = kms_pkg::MAP_SIZE'(1) << pos;
  assign rest       = pend_r & ~pos_bit;
  assign cur_press  = key_r[pos];
  assign fixed_mask = (kms_pkg::MAP_SIZE'(1) << kms_pkg::SHIFT_POS)
                    | (kms_pkg::MAP_SIZE'(1) << kms_pkg::SYM_POS);
  assign interval   = in_menu_active
                    ? ({1'b0, debounce_r, 2'b00} + kms_pkg::IVL_W'(debounce_r))
                    : kms_pkg::IVL_W'(debounce_r);

  always_comb begin
    sts.is_poll  = (in_kind == kms_pkg::KIND_POLL);
    sts.honored  = enable_r && (since_r >= kms_pkg::CNT_W'(interval));
    sts.cur_emit = (step_r < kms_pkg::POS_W'(2)) || pend_r[pos];
    sts.cur_last = (step_r != kms_pkg::POS_W'(0)) && (rest == '0);
    sts.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    since_nxt   = since_r;
    pressed_nxt = pressed_r;
    if (cmd.tick && since_r != kms_pkg::CNT_MAX) since_nxt = since_r + 1'b1;
    if (cmd.emit) begin
      pressed_nxt[pos] = cur_press;
      if (cur_press) since_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      debounce_r  <= '0;
      since_r     <= kms_pkg::CNT_MAX;
      pressed_r   <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          kms_pkg::CFG_ENABLE:   enable_r   <= cfg_data[0];
          kms_pkg::CFG_DEBOUNCE: debounce_r <= cfg_data;
          default: ;
        endcase
      end
      since_r   <= since_nxt;
      pressed_r <= pressed_nxt;
      if (cmd.load) begin
        step_r <= '0;
      end else if (cmd.advance && step_r != kms_pkg::LAST_STEP) begin
        step_r <= step_r + 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_key_down;
      pend_r <= (in_key_down | pressed_r) & ~fixed_mask;
    end else if (cmd.advance) begin
      pend_r <= rest;
    end
    if (cmd.emit) begin
      out_row_r      <= kms_pkg::pos_row(pos);
      out_column_r   <= kms_pkg::pos_col(pos);
      out_is_press_r <= cur_press;
      out_last_r     <= sts.cur_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_row      = out_row_r;
  assign out_column   = out_column_r;
  assign out_is_press = out_is_press_r;
  assign out_last     = out_last_r;

  `KMS_ASSERT_IMPLY(a_emit_slot_free, cmd.emit, !out_valid_r || out_ready)
  `KMS_ASSERT_NEXT(a_press_clears_count, cmd.emit && cur_press, since_r == '0)
  `KMS_ASSERT_NEXT(a_tick_monotone, cmd.tick && !cmd.emit, since_r >= $past(since_r))

endmodule

// ===== rtl/kms_ctrl.sv =====
// Controller of the key matrix event scanner: idle/scan sequencing.
// Depends on kms_pkg.
`timescale 1ns / 1ps

module kms_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kms_pkg::sts_t  sts,
  output kms_pkg::cmd_t  cmd
);

  kms_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kms_pkg::ST_IDLE: begin
        if (in_valid && sts.is_poll && sts.honored) state_nxt = kms_pkg::ST_SCAN;
      end
      kms_pkg::ST_SCAN: begin
        if (sts.cur_emit && sts.out_free && sts.cur_last) state_nxt = kms_pkg::ST_IDLE;
      end
      default: state_nxt = kms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      kms_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.tick = in_valid && !sts.is_poll;
        cmd.load = in_valid && sts.is_poll && sts.honored;
      end
      kms_pkg::ST_SCAN: begin
        cmd.emit    = sts.cur_emit && sts.out_free;
        cmd.advance = !sts.cur_emit || sts.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/key_matrix_event_scanner.sv =====
// Top level of the key matrix event scanner: controller plus datapath.
// Depends on kms_pkg, kms_ctrl and kms_datapath.
// An accepted honored poll loads the key and pending maps and enters ST_SCAN; the scan
// then registers the events of its steps into the output register up to its last event,
// holding while out_ready stalls. in_ready is low during a scan; in idle, ticks and ignored polls are taken.
// Reset (rst_n low, synchronous): enable=1, debounce=0, map cleared, counter saturated.
`timescale 1ns / 1ps

module key_matrix_event_scanner (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [kms_pkg::MAP_SIZE-1:0]    in_key_down,
  input  logic                            in_menu_active,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kms_pkg::ROW_W-1:0]       out_row,
  output logic [kms_pkg::COL_W-1:0]       out_column,
  output logic                            out_is_press,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kms_pkg::CFG_W-1:0]       cfg_index,
  input  logic [kms_pkg::DEB_W-1:0]       cfg_data
);

  kms_pkg::cmd_t cmd;
  kms_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  kms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kms_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_kind),
    .in_key_down    (in_key_down),
    .in_menu_active (in_menu_active),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_row        (out_row),
    .out_column     (out_column),
    .out_is_press   (out_is_press),
    .out_last       (out_last)
  );

endmodule
